@@ src/egd_pkg.sv @@
// Shared types and constants for the two-lead EMG gesture decoder.
// Used by every module under src; depends on nothing.
`default_nettype none

package egd_pkg;

	localparam int SAMPLE_BITS     = 10;
	localparam int CAL_SAMPLES_DEF = 50;
	localparam int QUEUE_DEPTH     = 2;

	// threshold dividers: floor(n / den) by reciprocal multiply plus one correction
	localparam int NUM_W     = SAMPLE_BITS + 2;
	localparam int DIV_SHIFT = 20;
	localparam int MUL_W     = 18;
	localparam int LVL_DEN   = 10;
	localparam int FALL_DEN  = 5;
	localparam int DIV10_MUL = (1 << DIV_SHIFT) / LVL_DEN;
	localparam int DIV5_MUL  = (1 << DIV_SHIFT) / FALL_DEN;

	localparam logic [1:0] CODE_REST   = 2'd0;
	localparam logic [1:0] CODE_LEAD_B = 2'd1;
	localparam logic [1:0] CODE_LEAD_A = 2'd2;
	localparam logic [1:0] CODE_BOTH   = 2'd3;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_a;
		logic [SAMPLE_BITS-1:0] sample_b;
	} sample_t;

	typedef struct packed {
		logic       calibrating;
		logic       sent;
		logic [1:0] code;
		logic       level_a;
		logic       level_b;
		logic       marker_pin;
	} result_t;

	// front to back word
	typedef struct packed {
		logic calibrating;
		logic level_a;
		logic level_b;
	} lead_word_t;

endpackage

`default_nettype wire

@@ src/two_channel_emg_gesture_decoder_core.sv @@
// Top level of the two-lead EMG gesture decoder: front end, word queue,
// back end. Depends on egd_pkg, egd_front, egd_queue, egd_back.
//
//   channel   dir  handshake                    word
//   sample    in   sample_valid / sample_stall  egd_pkg::sample_t
//   result    out  result_valid / result_stall  egd_pkg::result_t
//
// One sample pair per cycle while sample_stall is low; each pair is registered
// in the queue, then in the result register. After the last calibration word
// the input stalls through PH_FIN1 and PH_FIN2 while the threshold dividers (reciprocal multiply, then correct) finish.
// arst_n clears calibration, thresholds, lead levels, sequencer and queue.
// Front and back stall independently through the two-entry queue.
`default_nettype none

module two_channel_emg_gesture_decoder_core #(
	parameter int CAL_SAMPLES = egd_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire egd_pkg::sample_t  sample,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output egd_pkg::result_t       result
);

	logic                 q_full;
	logic                 push_valid;
	egd_pkg::lead_word_t  push_word;
	logic                 pop_valid;
	egd_pkg::lead_word_t  pop_word;
	logic                 pop_take;

	egd_front #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_full),
		.push_valid   (push_valid),
		.push_word    (push_word)
	);

	egd_queue #(
		.DEPTH (egd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_word   (pop_word),
		.pop_take   (pop_take)
	);

	egd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_word     (pop_word),
		.pop_take     (pop_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_marker_tracks_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sent |-> result.marker_pin == (result.code == egd_pkg::CODE_LEAD_B))
		else $error("marker does not follow sent code");

	a_cal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.calibrating |->
			!result.sent && !result.level_a && !result.level_b)
		else $error("calibration word carries decode output");

	a_unsent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sent |-> result.code == egd_pkg::CODE_REST)
		else $error("code nonzero without send");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> pop_valid && sample_stall)
		else $error("queue full flag inconsistent");

endmodule

`default_nettype wire

@@ src/egd_front.sv @@
// Front end: calibration tracking, threshold computation and per-lead
// slope/level qualification. Depends on egd_pkg.
`default_nettype none

module egd_front #(
	parameter int CAL_SAMPLES = egd_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire egd_pkg::sample_t    sample,
	input  wire logic                q_full,
	output logic                     push_valid,
	output egd_pkg::lead_word_t      push_word
);

	localparam int SB    = egd_pkg::SAMPLE_BITS;
	localparam int NW    = egd_pkg::NUM_W;
	localparam int PW    = egd_pkg::NUM_W + egd_pkg::MUL_W;
	localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

	typedef enum logic [1:0] {PH_CAL, PH_FIN1, PH_FIN2, PH_RUN} phase_t;

	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SB-1:0]      min_q      [2];
	logic [SB-1:0]      max_q      [2];
	logic [SB-1:0]      rise_q     [2];
	logic [SB-1:0]      fall_mag_q [2];
	logic [SB-1:0]      prev_q     [2];
	logic [SB-1:0]      lth_q      [2];
	logic [SB-1:0]      rth_q      [2];
	logic [SB-1:0]      fth_q      [2];
	logic               lead_q     [2];
	logic [NW-1:0]      lnum_s1    [2];
	logic [NW-1:0]      lq0_s1     [2];
	logic [NW-1:0]      fnum_s1    [2];
	logic [NW-1:0]      fq0_s1     [2];

	logic [SB-1:0]        s        [2];
	logic signed [SB:0]   slope    [2];
	logic signed [SB:0]   fall_lim [2];
	logic                 lv       [2];
	logic [NW-1:0]        lnum     [2];
	logic [NW-1:0]        fnum     [2];
	logic [PW-1:0]        lprod    [2];
	logic [PW-1:0]        fprod    [2];
	logic [NW-1:0]        lrem     [2];
	logic [NW-1:0]        frem     [2];
	logic [NW-1:0]        lq       [2];
	logic [NW-1:0]        fq       [2];
	logic                 accept;

	assign s[0] = sample.sample_a;
	assign s[1] = sample.sample_b;

	assign sample_stall = q_full || (phase_q == PH_FIN1) || (phase_q == PH_FIN2);
	assign accept       = sample_valid && !sample_stall;
	assign push_valid   = accept;

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			slope[ch]    = $signed({1'b0, s[ch]}) - $signed({1'b0, prev_q[ch]});
			fall_lim[ch] = -$signed({1'b0, fth_q[ch]});
			if (!lead_q[ch]) begin
				lv[ch] = (slope[ch] > $signed({1'b0, rth_q[ch]})) ||
					((s[ch] > lth_q[ch]) && (slope[ch] > 0));
			end else begin
				lv[ch] = !(((slope[ch] < 0) && (s[ch] < lth_q[ch])) ||
					(slope[ch] < fall_lim[ch]));
			end
			// span * 3 and fall magnitude * 4
			lnum[ch]  = NW'(max_q[ch] - min_q[ch]) + NW'({max_q[ch] - min_q[ch], 1'b0});
			fnum[ch]  = NW'({fall_mag_q[ch], 2'b00});
			lprod[ch] = PW'(lnum[ch]) * PW'(egd_pkg::DIV10_MUL);
			fprod[ch] = PW'(fnum[ch]) * PW'(egd_pkg::DIV5_MUL);
			// estimate is exact or one low
			lrem[ch]  = lnum_s1[ch] - NW'(lq0_s1[ch] * egd_pkg::LVL_DEN);
			frem[ch]  = fnum_s1[ch] - NW'(fq0_s1[ch] * egd_pkg::FALL_DEN);
			lq[ch]    = (lrem[ch] >= NW'(egd_pkg::LVL_DEN)) ? lq0_s1[ch] + NW'(1) : lq0_s1[ch];
			fq[ch]    = (frem[ch] >= NW'(egd_pkg::FALL_DEN)) ? fq0_s1[ch] + NW'(1) : fq0_s1[ch];
		end
	end

	always_comb begin
		push_word.calibrating = (phase_q == PH_CAL);
		push_word.level_a     = (phase_q == PH_RUN) && lv[0];
		push_word.level_b     = (phase_q == PH_RUN) && lv[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CAL;
			cnt_q   <= '0;
			for (int ch = 0; ch < 2; ch++) begin
				min_q[ch]      <= '1;
				max_q[ch]      <= '0;
				rise_q[ch]     <= '0;
				fall_mag_q[ch] <= '0;
				prev_q[ch]     <= '0;
				lth_q[ch]      <= '0;
				rth_q[ch]      <= '0;
				fth_q[ch]      <= '0;
				lead_q[ch]     <= 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_CAL: begin
					if (accept) begin
						for (int ch = 0; ch < 2; ch++) begin
							if (s[ch] > max_q[ch]) max_q[ch] <= s[ch];
							if (s[ch] < min_q[ch]) min_q[ch] <= s[ch];
							if (slope[ch] > $signed({1'b0, rise_q[ch]}))
								rise_q[ch] <= slope[ch][SB-1:0];
							if ((prev_q[ch] > s[ch]) &&
								((prev_q[ch] - s[ch]) > fall_mag_q[ch]))
								fall_mag_q[ch] <= prev_q[ch] - s[ch];
							prev_q[ch] <= s[ch];
						end
						if (cnt_q == CNT_W'(CAL_SAMPLES - 1)) phase_q <= PH_FIN1;
						else cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				PH_FIN1: begin
					phase_q <= PH_FIN2;
				end
				PH_FIN2: begin
					for (int ch = 0; ch < 2; ch++) begin
						lth_q[ch]  <= min_q[ch] + lq[ch][SB-1:0];
						rth_q[ch]  <= rise_q[ch] >> 1;
						fth_q[ch]  <= fq[ch][SB-1:0];
						prev_q[ch] <= '0;
					end
					phase_q <= PH_RUN;
				end
				PH_RUN: begin
					if (accept) begin
						for (int ch = 0; ch < 2; ch++) begin
							prev_q[ch] <= s[ch];
							lead_q[ch] <= lv[ch];
						end
					end
				end
			endcase
		end
	end

	// divider pipeline, loaded while thresholds are being finished
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			lnum_s1[ch] <= lnum[ch];
			fnum_s1[ch] <= fnum[ch];
			lq0_s1[ch]  <= NW'(lprod[ch] >> egd_pkg::DIV_SHIFT);
			fq0_s1[ch]  <= NW'(fprod[ch] >> egd_pkg::DIV_SHIFT);
		end
	end

endmodule

`default_nettype wire

@@ src/egd_queue.sv @@
// Short FIFO between front and back end, holds qualified lead words.
// Depends on egd_pkg.
`default_nettype none

module egd_queue #(
	parameter int DEPTH = egd_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	input  wire egd_pkg::lead_word_t  push_word,
	output logic                      full,
	output logic                      pop_valid,
	output egd_pkg::lead_word_t       pop_word,
	input  wire logic                 pop_take
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	egd_pkg::lead_word_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_word  = mem_q[rd_q];
	assign push      = push_valid && !full;
	assign pop       = pop_take && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

endmodule

`default_nettype wire

@@ src/egd_back.sv @@
// Back end: gesture code confirm/hold sequencer, marker latch and result
// register. Depends on egd_pkg.
`default_nettype none

module egd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	input  wire egd_pkg::lead_word_t  pop_word,
	output logic                      pop_take,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output egd_pkg::result_t          result
);

	typedef enum logic [1:0] {MD_IDLE, MD_CONFIRM, MD_HOLD} mode_t;

	mode_t            mode_q;
	logic [1:0]       pend_q;
	logic             marker_q;

	mode_t            mode_nxt;
	logic [1:0]       pend_nxt;
	logic             marker_nxt;
	logic             sent;
	logic [1:0]       code;
	logic [1:0]       cur;

	assign pop_take = pop_valid && (!result_valid || !result_stall);
	assign cur      = {pop_word.level_a, pop_word.level_b};

	always_comb begin
		mode_nxt = mode_q;
		pend_nxt = pend_q;
		sent     = 1'b0;
		code     = egd_pkg::CODE_REST;
		unique case (mode_q)
			MD_CONFIRM: begin
				sent = 1'b1;
				if (cur == pend_q)                 code = cur;
				else if (cur == egd_pkg::CODE_BOTH) code = egd_pkg::CODE_BOTH;
				mode_nxt = (code != egd_pkg::CODE_REST) ? MD_HOLD : MD_IDLE;
			end
			MD_HOLD: begin
				if (cur == egd_pkg::CODE_REST) begin
					sent     = 1'b1;
					mode_nxt = MD_IDLE;
				end
			end
			default: begin
				if (cur == egd_pkg::CODE_LEAD_A || cur == egd_pkg::CODE_LEAD_B) begin
					pend_nxt = cur;
					mode_nxt = MD_CONFIRM;
				end else begin
					sent     = 1'b1;
					code     = cur;
					mode_nxt = (cur == egd_pkg::CODE_BOTH) ? MD_HOLD : MD_IDLE;
				end
			end
		endcase
		marker_nxt = sent ? (code == egd_pkg::CODE_LEAD_B) : marker_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MD_IDLE;
			pend_q       <= egd_pkg::CODE_REST;
			marker_q     <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else if (pop_take) begin
			result_valid <= 1'b1;
			if (pop_word.calibrating) begin
				result.calibrating <= 1'b1;
				result.sent        <= 1'b0;
				result.code        <= egd_pkg::CODE_REST;
				result.level_a     <= 1'b0;
				result.level_b     <= 1'b0;
				result.marker_pin  <= marker_q;
			end else begin
				mode_q             <= mode_nxt;
				pend_q             <= pend_nxt;
				marker_q           <= marker_nxt;
				result.calibrating <= 1'b0;
				result.sent        <= sent;
				result.code        <= code;
				result.level_a     <= pop_word.level_a;
				result.level_b     <= pop_word.level_b;
				result.marker_pin  <= marker_nxt;
			end
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire
